// ===== design/assert_macros.svh =====
// Assertion helpers used by ahsd_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/ahsd_pkg.sv =====
package ahsd_pkg;
   localparam int unsigned SmpW   = 16;
   localparam int unsigned DiffW  = 18;
   localparam int unsigned SqW    = 38;
   localparam int unsigned CordW  = 30;

   localparam logic [2:0] RegWindow    = 3'd0;
   localparam logic [2:0] RegWeight    = 3'd1;
   localparam logic [2:0] RegMotionThr = 3'd2;
   localparam logic [2:0] RegRemoteThr = 3'd3;
   localparam logic [2:0] RegRemap     = 3'd4;

   typedef logic signed [SmpW-1:0] smp_type;

   typedef struct packed {
      logic    clear;
      smp_type rx, ry, rz, mx, my, mz;
   } job_type;

   typedef struct packed {
      logic        left_shake;
      logic [15:0] left_direction;
      logic        right_shake;
      logic [15:0] right_direction;
   } result_type;

   function automatic logic [15:0] atan_lookup(input logic [3:0] i);
      logic [15:0] r;
      unique case (i)
         4'd0: r = 16'd8192;   4'd1: r = 16'd4836;  4'd2: r = 16'd2555;
         4'd3: r = 16'd1297;   4'd4: r = 16'd651;   4'd5: r = 16'd326;
         4'd6: r = 16'd163;    4'd7: r = 16'd81;    4'd8: r = 16'd41;
         4'd9: r = 16'd20;     4'd10: r = 16'd10;   4'd11: r = 16'd5;
         4'd12: r = 16'd3;     4'd13: r = 16'd1;    4'd14: r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction
endpackage

// ===== design/ahsd_stream_if.sv =====
interface ahsd_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ahsd_csr_if.sv =====
interface ahsd_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/accel_history_shake_detector.sv =====
// Accelerometer history shake detector.
// req channel: one beat per frame, cmd (0 push and detect, 1 clear history)
//   plus remote and motion 3-axis Q5.10 samples.
// rsp channel: one beat per req beat, left (motion) and right (remote)
//   shake flags and 16-bit binary-angle directions (0 when no shake).
// csr channel: index 0..4 = window_samples, smoothing_weight,
//   motion_threshold, remote_threshold, remap_angle; write only when idle.
// A two-beat queue takes req beats while the back end works.
// A clear drops all valid marks and answers; a push stores the blended sample,
//   then per side walks the older slots of the window (capped at HISTORY_DEPTH).
//   The serial window walk takes one older slot per pass of the WALK, CMP and
//   THR states through the ring memory port, and a 16-step CORDIC runs per
//   shake, motion first, then remote. A queued beat starts in the cycle after
//   the previous rsp beat.
// Reset clears all valid marks, the newest-slot pointer and the registers
//   to their defaults; ring contents are undefined until written.
// When the rsp receiver stalls, the result is held and the back end waits;
//   the queue still takes up to two more req beats.
module accel_history_shake_detector import ahsd_pkg::*; #(
   parameter int unsigned HISTORY_DEPTH = 30
) (
   input  logic clock,
   input  logic reset,
   ahsd_stream_if.sink   req,
   ahsd_stream_if.source rsp,
   ahsd_csr_if.sink      csr
);
   logic [4:0]  window_ff;
   logic [8:0]  weight_ff;
   logic [14:0] mthr_ff, rthr_ff;
   logic [15:0] remap_ff;

   logic    q_valid, q_ready;
   job_type q_job;

   assign csr.ready = 1'b1;

   // hold configuration; decode writes by register index
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= 5'd5;
         weight_ff <= 9'd128;
         mthr_ff   <= 15'd2560;
         rthr_ff   <= 15'd1362;
         remap_ff  <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            RegWindow:    window_ff <= csr.data[4:0];
            RegWeight:    weight_ff <= csr.data[8:0];
            RegMotionThr: mthr_ff   <= csr.data[14:0];
            RegRemoteThr: rthr_ff   <= csr.data[14:0];
            RegRemap:     remap_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   ahsd_front #(.QueueDepth(2)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_job(req.payload),
      .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
   );

   ahsd_back #(.Depth(HISTORY_DEPTH)) u_back (
      .clock, .reset,
      .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
      .window_samples(window_ff), .smoothing_weight(weight_ff),
      .motion_threshold(mthr_ff), .remote_threshold(rthr_ff),
      .remap_angle(remap_ff),
      .res_valid(rsp.valid), .res_ready(rsp.ready), .res(rsp.payload)
   );
endmodule

// ===== design/ahsd_front.sv =====
module ahsd_front import ahsd_pkg::*; #(
   parameter int unsigned QueueDepth = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);
   localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   job_type          slots_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]    cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != (PtrW+1)'(QueueDepth));
   assign out_valid = (cnt_ff != '0);
   assign out_job   = slots_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PtrW'(QueueDepth-1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PtrW'(QueueDepth-1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slots_ff[wr_ff] <= in_job;
   end
endmodule

// ===== design/ahsd_back.sv =====
`include "assert_macros.svh"
module ahsd_back import ahsd_pkg::*; #(
   parameter int unsigned Depth = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   output logic        job_ready,
   input  job_type     job,
   input  logic [4:0]  window_samples,
   input  logic [8:0]  smoothing_weight,
   input  logic [14:0] motion_threshold,
   input  logic [14:0] remote_threshold,
   input  logic [15:0] remap_angle,
   output logic        res_valid,
   input  logic        res_ready,
   output result_type  res
);
   localparam int unsigned IdxW = $clog2(Depth);
   localparam int unsigned SpanW = $clog2(Depth+1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001, S_PREV  = 10'b0000000010,
      S_BLEND = 10'b0000000100, S_CUR   = 10'b0000001000,
      S_WALK  = 10'b0000010000, S_CMP   = 10'b0000100000,
      S_FOLD  = 10'b0001000000, S_THR   = 10'b0010000000,
      S_CORD  = 10'b0100000000, S_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff;
   logic [Depth-1:0] valid_ff;
   logic [IdxW-1:0]  newest_ff, addr_ff;
   logic             side_ff;   // 0 motion, 1 remote
   logic [SpanW-1:0] off_ff, span_ff;
   logic [3:0]       step_ff;

   // one memory per sensor, three axes per word
   logic [3*SmpW-1:0] mring [Depth];
   logic [3*SmpW-1:0] rring [Depth];
   logic [3*SmpW-1:0] mrd_ff, rrd_ff, cur_ff, wdata;
   logic              wen;
   logic [IdxW-1:0]   next_slot;
   job_type           job_ff;
   logic              blend_ff;

   logic signed [DiffW-1:0] dx_ff, dy_ff, dz_ff, bx_ff, by_ff, bz_ff;
   logic [SqW-1:0]          best_ff, mag_ff;
   logic                    found_ff;
   logic signed [CordW-1:0] cx_ff, cy_ff;
   logic [15:0]             cz_ff;
   logic                    ls_ff, rs_ff;
   logic [15:0]             ld_ff, rd_ff;
   logic                    res_valid_ff;

   assign next_slot = (newest_ff == IdxW'(Depth-1)) ? '0 : newest_ff + 1'b1;
   assign job_ready = (state_ff == S_IDLE) && !res_valid_ff;
   assign res_valid = res_valid_ff;
   assign res = '{ls_ff, ld_ff, rs_ff, rd_ff};

   function automatic logic signed [SmpW-1:0] blend_axis(
      input logic signed [SmpW-1:0] prev, input logic signed [SmpW-1:0] raw,
      input logic [8:0] w);
      logic signed [27:0] s;
      s = 28'(prev) * $signed({1'b0, 9'd256 - w}) + 28'(raw) * $signed({1'b0, w})
          + 28'sd128;
      return SmpW'(s >>> 8);
   endfunction

   logic [8:0] wsat;
   assign wsat = smoothing_weight[8] ? 9'd256 : smoothing_weight;

   logic [3*SmpW-1:0] sel_rd;
   assign sel_rd = side_ff ? rrd_ff : mrd_ff;

   // fold and cordic helpers
   logic signed [DiffW-1:0] fy, ady, adz;
   assign ady = bz_ff[DiffW-1] ? -bz_ff : bz_ff;
   assign adz = by_ff[DiffW-1] ? -by_ff : by_ff;
   assign fy  = (adz < ady) ? bz_ff : -by_ff;
   logic signed [CordW-1:0] xs, ys;
   assign xs = cx_ff >>> step_ff;
   assign ys = cy_ff >>> step_ff;
   logic [2*15-1:0] thr_sq;
   logic [14:0] thr;
   assign thr = side_ff ? remote_threshold : motion_threshold;
   assign thr_sq = thr * thr;

   always_ff @(posedge clock) begin
      if (wen) begin
         mring[next_slot] <= wdata[3*SmpW-1:0];
         rring[next_slot] <= job_ff.clear ? '0 :
            {blend_ff ? blend_axis(rrd_ff[47:32], job_ff.rx, wsat) : job_ff.rx,
             blend_ff ? blend_axis(rrd_ff[31:16], job_ff.ry, wsat) : job_ff.ry,
             blend_ff ? blend_axis(rrd_ff[15:0],  job_ff.rz, wsat) : job_ff.rz};
      end
      mrd_ff <= mring[addr_ff];
      rrd_ff <= rring[addr_ff];
   end

   assign wdata = {blend_ff ? blend_axis(mrd_ff[47:32], job_ff.mx, wsat) : job_ff.mx,
                   blend_ff ? blend_axis(mrd_ff[31:16], job_ff.my, wsat) : job_ff.my,
                   blend_ff ? blend_axis(mrd_ff[15:0],  job_ff.mz, wsat) : job_ff.mz};
   assign wen = (state_ff == S_BLEND);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         newest_ff    <= '0;
         res_valid_ff <= 1'b0;
         addr_ff      <= '0;
      end else begin
         if (res_valid_ff && res_ready) res_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (job_valid && job_ready) begin
               job_ff <= job;
               addr_ff <= newest_ff;
               ls_ff <= 1'b0; rs_ff <= 1'b0; ld_ff <= '0; rd_ff <= '0;
               if (job.clear) begin
                  valid_ff <= '0;
                  state_ff <= S_DONE;
               end else state_ff <= S_PREV;
            end
            S_PREV: begin
               blend_ff <= valid_ff[newest_ff];
               state_ff <= S_BLEND;
            end
            S_BLEND: begin
               valid_ff[next_slot] <= 1'b1;
               newest_ff <= next_slot;
               addr_ff   <= next_slot;
               side_ff   <= 1'b0;
               state_ff  <= S_CUR;
            end
            S_CUR: begin
               // read data of newest slot arrives next cycle
               span_ff  <= (int'(window_samples) > Depth) ? SpanW'(Depth)
                                                          : SpanW'(window_samples);
               off_ff   <= SpanW'(1);
               best_ff  <= '0;
               found_ff <= 1'b0;
               state_ff <= S_WALK;
               addr_ff  <= (newest_ff == '0) ? IdxW'(Depth-1) : newest_ff - 1'b1;
               step_ff  <= 4'd0;
            end
            S_WALK: begin
               // latch newest entry once, then one older slot per pass; after the latch the read
               // data belongs to addr_ff
               if (step_ff == 4'd0) begin
                  cur_ff  <= sel_rd;
                  step_ff <= 4'd1;
               end else if (off_ff >= span_ff || !valid_ff[addr_ff]) begin
                  state_ff <= S_FOLD;
               end else begin
                  dx_ff <= DiffW'($signed(cur_ff[47:32])) - DiffW'($signed(sel_rd[47:32]));
                  dy_ff <= DiffW'($signed(cur_ff[31:16])) - DiffW'($signed(sel_rd[31:16]));
                  dz_ff <= DiffW'($signed(cur_ff[15:0]))  - DiffW'($signed(sel_rd[15:0]));
                  addr_ff <= (addr_ff == '0) ? IdxW'(Depth-1) : addr_ff - 1'b1;
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               mag_ff <= SqW'(dx_ff*dx_ff) + SqW'(dy_ff*dy_ff) + SqW'(dz_ff*dz_ff);
               state_ff <= S_THR;
            end
            S_THR: begin
               if (mag_ff > best_ff) begin
                  best_ff <= mag_ff; found_ff <= 1'b1;
                  bx_ff <= dx_ff; by_ff <= dy_ff; bz_ff <= dz_ff;
               end
               off_ff  <= off_ff + 1'b1;
               state_ff <= S_WALK;
            end
            S_FOLD: begin
               // angle operands are (-dx, fy); turn by half a turn when -dx < 0
               if (found_ff && (SqW'(bx_ff*bx_ff) + SqW'(fy*fy) > SqW'(thr_sq))) begin
                  cx_ff <= (bx_ff > 0) ? CordW'(bx_ff) <<< 8 : CordW'(-bx_ff) <<< 8;
                  cy_ff <= (bx_ff > 0) ? CordW'(-fy) <<< 8 : CordW'(fy) <<< 8;
                  cz_ff <= (bx_ff > 0) ? 16'd32768 : 16'd0;
                  step_ff <= 4'd0;
                  state_ff <= S_CORD;
               end else state_ff <= S_DONE;
               if (!side_ff) ls_ff <= 1'b0; else rs_ff <= 1'b0;
            end
            S_CORD: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs;
                  cz_ff <= cz_ff + atan_lookup(step_ff);
               end else begin
                  cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs;
                  cz_ff <= cz_ff - atan_lookup(step_ff);
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd15) state_ff <= S_DONE;
               if (step_ff == 4'd15) begin
                  if (!side_ff) begin ls_ff <= 1'b1; ld_ff <= cz_ff + (cy_ff > 0 ?
                     atan_lookup(step_ff) : -atan_lookup(step_ff)) + remap_angle; end
                  else begin rs_ff <= 1'b1; rd_ff <= cz_ff + (cy_ff > 0 ?
                     atan_lookup(step_ff) : -atan_lookup(step_ff)) + remap_angle; end
               end
            end
            S_DONE: begin
               if (!job_ff.clear && !side_ff) begin
                  side_ff <= 1'b1;
                  addr_ff <= newest_ff;
                  state_ff <= S_CUR;
               end else begin
                  res_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_IMPL(a_res_idle, clock, reset, res_valid_ff, state_ff == S_IDLE)
   `ASSERT_IMPL(a_newest_valid, clock, reset, state_ff == S_WALK, valid_ff[newest_ff])
   `ASSERT_NEXT(a_clear_marks, clock, reset,
      state_ff == S_IDLE && job_valid && job_ready && job.clear, valid_ff == '0)
endmodule
